FILE: rtl/iecm_pkg.sv
// ============================================================================
// iecm_pkg
// Shared types, constants and the log2 table of the IEC level meter ballistics core.
// ============================================================================
`default_nettype none

package iecm_pkg;

    // Field widths fixed by the interface
    localparam int AMP_W  = 18;
    localparam int FS_W   = 12;
    localparam int HOLD_W = 8;
    localparam int ZONE_W = 3;
    localparam int DB_W   = 16;   // signed Q8.8
    localparam int N_W    = 17;   // IEC scale in units of 1/102400
    localparam int MAG_W  = 13;   // magnitude of log2 in Q.8
    localparam int Y_W    = 17;   // full_scale * n / 4096

    // Configuration register indexes
    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_PEAK_HOLD  = 1'b1;

    // Peak zone codes
    localparam logic [ZONE_W-1:0] ZONE_OVER = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_0DB  = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_3DB  = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_6DB  = 3'd3;

    // dB conversion constants
    localparam logic [18:0] LOG_TO_DB = 19'd394567;   // 20*log10(2) in Q.16
    localparam logic [16:0] DB_NEG_LIMIT = 17'd17920; // 70 dB in Q8.8
    localparam logic [15:0] DB_POS_LIMIT = 16'd1024;  // 4 dB in Q8.8
    localparam logic signed [DB_W-1:0] DB_MIN = -16'sd17920;
    localparam logic signed [DB_W-1:0] DB_MAX = 16'sd1024;

    // floor(y / 25) via reciprocal, low by at most one
    localparam logic [12:0] DIV25_RECIP = 13'd5242;
    localparam logic [5:0]  DIV25       = 6'd25;
    // floor(x / 5) for x below 2^15, exact
    localparam logic [15:0] DIV5_RECIP  = 16'd52429;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG,
        ST_DB,
        ST_IEC,
        ST_LV,
        ST_DIV,
        ST_BAR,
        ST_BSQ,
        ST_PEAK,
        ST_PSQ,
        ST_OUT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOG,
        OP_DB,
        OP_IEC,
        OP_LV,
        OP_DIV,
        OP_BAR,
        OP_BSQ,
        OP_PEAK,
        OP_PSQ
    } t_op;

    typedef struct packed {
        logic load_in;
        t_op  op;
        logic load_out;
    } t_cmd;

    // log2 mantissa table in Q.8, 17 points
    function automatic logic [8:0] log_tab(input logic [4:0] idx);
        logic [8:0] v;
        case (idx)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd22;
            5'd2:    v = 9'd44;
            5'd3:    v = 9'd63;
            5'd4:    v = 9'd82;
            5'd5:    v = 9'd100;
            5'd6:    v = 9'd118;
            5'd7:    v = 9'd134;
            5'd8:    v = 9'd150;
            5'd9:    v = 9'd165;
            5'd10:   v = 9'd179;
            5'd11:   v = 9'd193;
            5'd12:   v = 9'd207;
            5'd13:   v = 9'd220;
            5'd14:   v = 9'd232;
            5'd15:   v = 9'd244;
            default: v = 9'd256;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/iecm_ctrl.sv
// ============================================================================
// iecm_ctrl
// Sequencer: walks one request through the datapath steps and owns the
// input and output handshakes.
// ============================================================================
`default_nettype none

module iecm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output iecm_pkg::t_cmd   o_cmd
);

    iecm_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iecm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.load_in  = 1'b0;
        o_cmd.op       = iecm_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            iecm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = iecm_pkg::ST_LOG;
                end
            end
            iecm_pkg::ST_LOG: begin
                o_cmd.op = iecm_pkg::OP_LOG;
                n_state  = iecm_pkg::ST_DB;
            end
            iecm_pkg::ST_DB: begin
                o_cmd.op = iecm_pkg::OP_DB;
                n_state  = iecm_pkg::ST_IEC;
            end
            iecm_pkg::ST_IEC: begin
                o_cmd.op = iecm_pkg::OP_IEC;
                n_state  = iecm_pkg::ST_LV;
            end
            iecm_pkg::ST_LV: begin
                o_cmd.op = iecm_pkg::OP_LV;
                n_state  = iecm_pkg::ST_DIV;
            end
            iecm_pkg::ST_DIV: begin
                o_cmd.op = iecm_pkg::OP_DIV;
                n_state  = iecm_pkg::ST_BAR;
            end
            iecm_pkg::ST_BAR: begin
                o_cmd.op = iecm_pkg::OP_BAR;
                n_state  = iecm_pkg::ST_BSQ;
            end
            iecm_pkg::ST_BSQ: begin
                o_cmd.op = iecm_pkg::OP_BSQ;
                n_state  = iecm_pkg::ST_PEAK;
            end
            iecm_pkg::ST_PEAK: begin
                o_cmd.op = iecm_pkg::OP_PEAK;
                n_state  = iecm_pkg::ST_PSQ;
            end
            iecm_pkg::ST_PSQ: begin
                o_cmd.op = iecm_pkg::OP_PSQ;
                n_state  = iecm_pkg::ST_OUT;
            end
            iecm_pkg::ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = iecm_pkg::ST_IDLE;
                end
            end
            default: n_state = iecm_pkg::ST_IDLE;
        endcase
    end

    // output valid holds until taken
    always_comb begin
        if (o_cmd.load_out)
            n_out_valid = 1'b1;
        else
            n_out_valid = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/iecm_dp.sv
// ============================================================================
// iecm_dp
// Datapath: log/dB conversion, IEC scale, ballistics state and one shared
// multiplier, stepped by the sequencer.
// ============================================================================
`default_nettype none

module iecm_dp #(
    parameter int LB = 12,
    parameter int DF = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  iecm_pkg::t_cmd                    i_cmd,
    input  wire [iecm_pkg::AMP_W-1:0]         i_amplitude,
    input  wire                               i_clear_peak,
    input  wire [iecm_pkg::FS_W-1:0]          i_full_scale,
    input  wire [iecm_pkg::HOLD_W-1:0]        i_peak_hold,
    output logic [LB-1:0]                     o_bar_level,
    output logic [LB-1:0]                     o_peak_level,
    output logic [iecm_pkg::ZONE_W-1:0]       o_peak_zone
);

    localparam logic [63:0]    ONE      = 64'd1 << DF;
    localparam logic [63:0]    BAR_RW   = (ONE * 64'd97 + 64'd50) / 64'd100;
    localparam logic [63:0]    PEAK_RW  = ONE - (ONE * 64'd3 + 64'd500000) / 64'd1000000;
    localparam logic [DF-1:0]  BAR_RST  = BAR_RW[DF-1:0];
    localparam logic [DF-1:0]  PEAK_RST = PEAK_RW[DF-1:0];
    localparam logic [31:0]    LVL_MAX32 = (32'd1 << LB) - 32'd1;
    localparam logic [LB-1:0]  LVL_MAX  = LVL_MAX32[LB-1:0];
    localparam logic [iecm_pkg::HOLD_W-1:0] FRAMES_MAX = '1;

    // request and intermediate registers
    logic [iecm_pkg::AMP_W-1:0]        r_amp;
    logic                              r_clr;
    logic                              r_zero, r_lg_neg;
    logic [iecm_pkg::MAG_W-1:0]        r_lg_mag;
    logic signed [iecm_pkg::DB_W-1:0]  r_db;
    logic [iecm_pkg::N_W-1:0]          r_n;
    logic [iecm_pkg::Y_W-1:0]          r_y;
    logic [LB-1:0]                     r_level;
    logic [LB-1:0]                     r_l10, r_l6, r_l3;

    // ballistics state
    logic [LB-1:0]                     r_bar_hold, r_peak_pos;
    logic [DF-1:0]                     r_bar_decay, r_peak_decay;
    logic                              r_bar_sq, r_peak_sq;
    logic [iecm_pkg::HOLD_W-1:0]       r_peak_frames;
    logic [iecm_pkg::ZONE_W-1:0]       r_peak_zone;

    // output register
    logic [LB-1:0]                     r_out_bar, r_out_peak;
    logic [iecm_pkg::ZONE_W-1:0]       r_out_zone;

    // ------------------------------------------------------------------
    // leading one, normalize, table lookup with interpolation
    logic [4:0]                        lo_pos;
    logic [4:0]                        lo_sh;
    logic [iecm_pkg::AMP_W-1:0]        lo_m;
    logic [8:0]                        lo_t0, lo_t1, lo_diff, lo_frac;
    logic [16:0]                       lo_prod;
    logic                              lo_neg;
    logic [iecm_pkg::MAG_W-1:0]        lo_mag;

    always_comb begin
        lo_pos = '0;
        for (int k = 0; k < iecm_pkg::AMP_W; k++) begin
            if (r_amp[k])
                lo_pos = 5'(k);
        end
        lo_sh   = 5'd17 - lo_pos;
        lo_m    = r_amp << lo_sh;
        lo_t0   = iecm_pkg::log_tab({1'b0, lo_m[16:13]});
        lo_t1   = iecm_pkg::log_tab({1'b0, lo_m[16:13]} + 5'd1);
        lo_diff = lo_t1 - lo_t0;
        lo_prod = lo_diff * lo_m[12:5];
        lo_frac = lo_t0 + 9'(lo_prod >> 8);
        lo_neg  = lo_pos < 5'd16;
        if (lo_neg)
            lo_mag = {5'd16 - lo_pos, 8'd0} - {4'd0, lo_frac};
        else
            lo_mag = {lo_pos - 5'd16, 8'd0} + {4'd0, lo_frac};
    end

    // ------------------------------------------------------------------
    // shared multiplier
    logic [DF-1:0]   mul_a, mul_b;
    logic [2*DF-1:0] mul_p;
    logic [LB-1:0]   peak_base;

    assign peak_base = r_clr ? '0 : r_peak_pos;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            iecm_pkg::OP_DB: begin
                mul_a = DF'(r_lg_mag);
                mul_b = DF'(iecm_pkg::LOG_TO_DB);
            end
            iecm_pkg::OP_LV: begin
                mul_a = DF'(i_full_scale);
                mul_b = DF'(r_n);
            end
            iecm_pkg::OP_DIV: begin
                mul_a = DF'(r_y);
                mul_b = DF'(iecm_pkg::DIV25_RECIP);
            end
            iecm_pkg::OP_BAR: begin
                mul_a = DF'(r_bar_hold);
                mul_b = r_bar_decay;
            end
            iecm_pkg::OP_BSQ: begin
                mul_a = r_bar_decay;
                mul_b = r_bar_decay;
            end
            iecm_pkg::OP_PEAK: begin
                mul_a = DF'(peak_base);
                mul_b = r_peak_decay;
            end
            iecm_pkg::OP_PSQ: begin
                mul_a = r_peak_decay;
                mul_b = r_peak_decay;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // dB from log2, rounded toward minus infinity, clamped
    logic [31:0]                       db_pm;
    logic [32:0]                       db_up;
    logic signed [iecm_pkg::DB_W-1:0]  db_val;

    always_comb begin
        db_pm = mul_p[31:0];
        db_up = {1'b0, db_pm} + 33'd65535;
        if (r_zero)
            db_val = iecm_pkg::DB_MIN;
        else if (r_lg_neg) begin
            if (db_up[32:16] > iecm_pkg::DB_NEG_LIMIT)
                db_val = iecm_pkg::DB_MIN;
            else
                db_val = -$signed(db_up[31:16]);
        end else begin
            if (db_pm[31:16] > iecm_pkg::DB_POS_LIMIT)
                db_val = iecm_pkg::DB_MAX;
            else
                db_val = $signed(db_pm[31:16]);
        end
    end

    // ------------------------------------------------------------------
    // six-segment IEC scale in units of 1/102400
    logic signed [19:0] iec_d, iec_n;

    always_comb begin
        iec_d = 20'(r_db);
        if (iec_d < -20'sd15360)
            iec_n = iec_d + 20'sd17920;
        else if (iec_d < -20'sd12800)
            iec_n = 20'sd2560 + 20'sd2 * (iec_d + 20'sd15360);
        else if (iec_d < -20'sd10240)
            iec_n = 20'sd7680 + 20'sd3 * (iec_d + 20'sd12800);
        else if (iec_d < -20'sd7680)
            iec_n = 20'sd15360 + 20'sd6 * (iec_d + 20'sd10240);
        else if (iec_d < -20'sd5120)
            iec_n = 20'sd30720 + 20'sd8 * (iec_d + 20'sd7680);
        else
            iec_n = 20'sd51200 + 20'sd10 * (iec_d + 20'sd5120);
    end

    // ------------------------------------------------------------------
    // y / 25 with one correction step, then saturate
    logic [12:0]               dv_q0, dv_q;
    logic [iecm_pkg::Y_W-1:0]  dv_rem;
    logic [LB-1:0]             dv_level;

    always_comb begin
        dv_q0  = mul_p[29:17];
        dv_rem = r_y - (iecm_pkg::Y_W'(dv_q0) * iecm_pkg::Y_W'(iecm_pkg::DIV25));
        dv_q   = (dv_rem >= iecm_pkg::Y_W'(iecm_pkg::DIV25)) ? dv_q0 + 13'd1 : dv_q0;
        if (32'(dv_q) > LVL_MAX32)
            dv_level = LVL_MAX;
        else
            dv_level = LB'(dv_q);
    end

    // ------------------------------------------------------------------
    // zone thresholds at -10, -6 and -3 dB: fs*3/4, fs*17/20, fs*37/40
    logic [13:0] th_10;
    logic [14:0] th_6x, th_3x;
    logic [31:0] th_6p, th_3p;
    logic [31:0] th_10w, th_6w, th_3w;

    always_comb begin
        th_10  = 14'(({2'd0, i_full_scale} * 14'd3) >> 2);
        th_6x  = 15'(({5'd0, i_full_scale} * 17'd17) >> 2);
        th_3x  = 15'(({6'd0, i_full_scale} * 18'd37) >> 3);
        th_6p  = {17'd0, th_6x} * {16'd0, iecm_pkg::DIV5_RECIP};
        th_3p  = {17'd0, th_3x} * {16'd0, iecm_pkg::DIV5_RECIP};
        th_10w = 32'(th_10);
        th_6w  = th_6p >> 18;
        th_3w  = th_3p >> 18;
    end

    always_ff @(posedge i_clk) begin
        r_l10 <= (th_10w > LVL_MAX32) ? LVL_MAX : LB'(th_10w);
        r_l6  <= (th_6w  > LVL_MAX32) ? LVL_MAX : LB'(th_6w);
        r_l3  <= (th_3w  > LVL_MAX32) ? LVL_MAX : LB'(th_3w);
    end

    // ------------------------------------------------------------------
    // decayed positions and zone of the current level
    logic [LB-1:0]               dec_h;
    logic [DF-1:0]               sq_f;
    logic [iecm_pkg::ZONE_W-1:0] lvl_zone;

    assign dec_h = mul_p[DF+LB-1:DF];
    assign sq_f  = mul_p[2*DF-1:DF];

    always_comb begin
        if (r_level < r_l10)
            lvl_zone = iecm_pkg::ZONE_6DB;
        else if (r_level < r_l6)
            lvl_zone = iecm_pkg::ZONE_3DB;
        else if (r_level < r_l3)
            lvl_zone = iecm_pkg::ZONE_0DB;
        else
            lvl_zone = iecm_pkg::ZONE_OVER;
    end

    // ------------------------------------------------------------------
    // request pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_amp <= i_amplitude;
            r_clr <= i_clear_peak;
        end
        case (i_cmd.op)
            iecm_pkg::OP_LOG: begin
                r_zero   <= (r_amp == '0);
                r_lg_neg <= lo_neg;
                r_lg_mag <= lo_mag;
            end
            iecm_pkg::OP_DB:  r_db <= db_val;
            iecm_pkg::OP_IEC: r_n  <= (iec_n < 0) ? '0 : iecm_pkg::N_W'(iec_n);
            iecm_pkg::OP_LV:  r_y  <= mul_p[28:12];
            iecm_pkg::OP_DIV: r_level <= dv_level;
            iecm_pkg::OP_BAR: begin
                if (!(r_bar_hold < r_level) && !(dec_h < r_level))
                    r_level <= dec_h;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out_bar  <= r_bar_hold;
            r_out_peak <= r_peak_pos;
            r_out_zone <= r_peak_zone;
        end
    end

    // ------------------------------------------------------------------
    // bar and peak ballistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_hold    <= '0;
            r_bar_decay   <= BAR_RST;
            r_bar_sq      <= 1'b0;
            r_peak_pos    <= '0;
            r_peak_frames <= '0;
            r_peak_decay  <= PEAK_RST;
            r_peak_sq     <= 1'b0;
            r_peak_zone   <= iecm_pkg::ZONE_6DB;
        end else begin
            case (i_cmd.op)
                iecm_pkg::OP_BAR: begin
                    r_bar_sq <= 1'b0;
                    if (r_bar_hold < r_level) begin
                        // rise: jump up, rearm decay
                        r_bar_hold  <= r_level;
                        r_bar_decay <= BAR_RST;
                    end else if (dec_h < r_level) begin
                        r_bar_hold <= r_level;
                    end else begin
                        r_bar_hold <= dec_h;
                        r_bar_sq   <= 1'b1;
                    end
                end
                iecm_pkg::OP_BSQ: begin
                    if (r_bar_sq)
                        r_bar_decay <= sq_f;
                end
                iecm_pkg::OP_PEAK: begin
                    r_peak_sq <= 1'b0;
                    if (peak_base < r_level) begin
                        // new peak
                        r_peak_pos    <= r_level;
                        r_peak_frames <= '0;
                        r_peak_decay  <= PEAK_RST;
                        r_peak_zone   <= lvl_zone;
                    end else begin
                        if (r_peak_frames != FRAMES_MAX)
                            r_peak_frames <= r_peak_frames + 1'b1;
                        if (r_peak_frames >= i_peak_hold) begin
                            if (dec_h < r_level) begin
                                r_peak_pos <= r_level;
                            end else begin
                                r_peak_pos <= dec_h;
                                r_peak_sq  <= 1'b1;
                                if (dec_h < r_l10)
                                    r_peak_zone <= iecm_pkg::ZONE_6DB;
                            end
                        end else begin
                            r_peak_pos <= peak_base;
                        end
                    end
                end
                iecm_pkg::OP_PSQ: begin
                    if (r_peak_sq)
                        r_peak_decay <= sq_f;
                end
                default: ;
            endcase
        end
    end

    assign o_bar_level  = r_out_bar;
    assign o_peak_level = r_out_peak;
    assign o_peak_zone  = r_out_zone;

endmodule

`default_nettype wire

FILE: rtl/iec_level_meter_ballistics_core.sv
// One request at a time: the input stalls while the sequencer steps it through
// log, dB, IEC scale, level, divide, bar, bar square, peak and peak square
// around the single shared multiplier, then loads the output register.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// the meter state, and restores full_scale 255 and peak_hold_frames 16.
// ============================================================================
// iec_level_meter_ballistics_core
// IEC 60268 peak meter with bar ballistics, peak hold and zone report.
// ============================================================================
`default_nettype none

module iec_level_meter_ballistics_core #(
    parameter int LEVEL_BITS      = 12,
    parameter int DECAY_FRAC_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // request channel
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [iecm_pkg::AMP_W-1:0]       i_amplitude,
    input  wire                             i_clear_peak,
    // result channel
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [LEVEL_BITS-1:0]           o_bar_level,
    output logic [LEVEL_BITS-1:0]           o_peak_level,
    output logic [iecm_pkg::ZONE_W-1:0]     o_peak_zone,
    // configuration port
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [2:0]                       paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [iecm_pkg::FS_W-1:0]   r_full_scale;
    logic [iecm_pkg::HOLD_W-1:0] r_peak_hold;
    logic                        cfg_wr;
    iecm_pkg::t_cmd              cmd;

    // register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= 12'd255;
            r_peak_hold  <= 8'd16;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                iecm_pkg::REG_FULL_SCALE: r_full_scale <= pwdata[iecm_pkg::FS_W-1:0];
                iecm_pkg::REG_PEAK_HOLD:  r_peak_hold  <= pwdata[iecm_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[2])
            iecm_pkg::REG_FULL_SCALE: prdata = 32'(r_full_scale);
            iecm_pkg::REG_PEAK_HOLD:  prdata = 32'(r_peak_hold);
            default:                  prdata = '0;
        endcase
    end

    iecm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    iecm_dp #(
        .LB (LEVEL_BITS),
        .DF (DECAY_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_amplitude  (i_amplitude),
        .i_clear_peak (i_clear_peak),
        .i_full_scale (r_full_scale),
        .i_peak_hold  (r_peak_hold),
        .o_bar_level  (o_bar_level),
        .o_peak_level (o_peak_level),
        .o_peak_zone  (o_peak_zone)
    );

endmodule

`default_nettype wire

FILE: rtl/iecm_chk.sv
// ============================================================================
// iecm_chk
// Port-level checks of the meter core, bound to the top level.
// ============================================================================
`default_nettype none

module iecm_chk #(
    parameter int LB = 12
) (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_in_valid,
    input wire          o_in_stall,
    input wire          o_out_valid,
    input wire          i_out_stall,
    input wire [LB-1:0] o_bar_level,
    input wire [LB-1:0] o_peak_level,
    input wire [2:0]    o_peak_zone
);

    // one request in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous still in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_bar_level)
                                          && $stable(o_peak_level)))
        else $error("stalled result changed");

    // the peak marker never sits below the bar
    a_peak_ge_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_level >= o_bar_level))
        else $error("peak marker below bar");

    // zone codes above 3 are never reported
    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_zone <= 3'd3))
        else $error("peak zone out of range");

endmodule

bind iec_level_meter_ballistics_core iecm_chk #(.LB(LEVEL_BITS)) u_iecm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_bar_level  (o_bar_level),
    .o_peak_level (o_peak_level),
    .o_peak_zone  (o_peak_zone)
);

`default_nettype wire
